// ===== rtl/nnba_pkg.sv =====
// ----------------------------------------------------------------------------
// nnba_pkg
// Types, field widths, register indexes and the division step shared by the
// nearest-neighbor blit addresser.
// ----------------------------------------------------------------------------
package nnba_pkg;

    localparam int POS_W    = 12;  // column/row within region
    localparam int ORG_W    = 13;  // origin on canvas
    localparam int SIZE_W   = 13;  // source/region dimensions
    localparam int CANW_W   = 14;  // canvas row length
    localparam int CH_W     = 3;   // channel counts
    localparam int NUM_W    = POS_W + SIZE_W;  // scaled position (dividend)
    localparam int SRCA_W   = 26;
    localparam int CANA_W   = 28;
    localparam int CIDX_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_CHANNELS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_CHANNELS = 3'd6;

    typedef struct packed {
        logic [POS_W-1:0] region_col;
        logic [POS_W-1:0] region_row;
        logic [ORG_W-1:0] origin_x;
        logic [ORG_W-1:0] origin_y;
    } t_in;

    typedef struct packed {
        logic [SRCA_W-1:0] source_address;
        logic [CANA_W-1:0] canvas_address;
        logic [CIDX_W-1:0] channel_index;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [SIZE_W-1:0] src_width;
        logic [SIZE_W-1:0] src_height;
        logic [CH_W-1:0]   src_channels;
        logic [SIZE_W-1:0] region_width;
        logic [SIZE_W-1:0] region_height;
        logic [CANW_W-1:0] canvas_width;
        logic [CH_W-1:0]   canvas_channels;
    } t_cfg;

    // Canvas pixel coordinates carried alongside the divisions
    typedef struct packed {
        logic [CANW_W-1:0] cy;
        logic [CANW_W-1:0] cx;
    } t_div_side;

    // Per-pixel base addresses handed from front to back
    typedef struct packed {
        logic [SRCA_W-1:0] src_base;
        logic [CANA_W-1:0] can_base;
    } t_entry;

    // One restoring division step: returns {new remainder, quotient bit}
    function automatic logic [SIZE_W:0] div_step(
        input logic [SIZE_W-1:0] rem,
        input logic              in_bit,
        input logic [SIZE_W-1:0] den
    );
        logic [SIZE_W:0] trial;
        logic [SIZE_W:0] diff;
        trial = {rem, in_bit};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den}) begin
            div_step = {diff[SIZE_W-1:0], 1'b1};
        end else begin
            div_step = {trial[SIZE_W-1:0], 1'b0};
        end
    endfunction

endpackage

// ===== rtl/nnba_div.sv =====
// ----------------------------------------------------------------------------
// nnba_div
// Two-lane pipelined restoring divider, one quotient bit per stage. Divisors come
// from configuration; the user must keep them stable while items are in flight.
// ----------------------------------------------------------------------------
module nnba_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [nnba_pkg::NUM_W-1:0]       i_num_x,
    input  logic [nnba_pkg::NUM_W-1:0]       i_num_y,
    input  logic [nnba_pkg::SIZE_W-1:0]      i_den_x,
    input  logic [nnba_pkg::SIZE_W-1:0]      i_den_y,
    input  nnba_pkg::t_div_side              i_side,
    output logic                             o_valid,
    output logic [nnba_pkg::NUM_W-1:0]       o_quo_x,
    output logic [nnba_pkg::NUM_W-1:0]       o_quo_y,
    output nnba_pkg::t_div_side              o_side
);

    localparam int NW = nnba_pkg::NUM_W;
    localparam int DW = nnba_pkg::SIZE_W;

    logic [DW-1:0]        r_rx   [NW];
    logic [DW-1:0]        r_ry   [NW];
    logic [NW-1:0]        r_qx   [NW];
    logic [NW-1:0]        r_qy   [NW];
    logic [NW-1:0]        r_nx   [NW];
    logic [NW-1:0]        r_ny   [NW];
    nnba_pkg::t_div_side  r_side [NW];
    logic                 r_v    [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW-1:0]       p_rx, p_ry;
        logic [NW-1:0]       p_qx, p_qy, p_nx, p_ny;
        nnba_pkg::t_div_side p_side;
        logic                p_v;
        logic [DW:0]         n_stx, n_sty;

        // Select the previous stage, or the pipeline input for the first one
        if (k == 0) begin : g_first
            assign p_rx   = '0;
            assign p_ry   = '0;
            assign p_qx   = '0;
            assign p_qy   = '0;
            assign p_nx   = i_num_x;
            assign p_ny   = i_num_y;
            assign p_side = i_side;
            assign p_v    = i_valid;
        end else begin : g_next
            assign p_rx   = r_rx[k-1];
            assign p_ry   = r_ry[k-1];
            assign p_qx   = r_qx[k-1];
            assign p_qy   = r_qy[k-1];
            assign p_nx   = r_nx[k-1];
            assign p_ny   = r_ny[k-1];
            assign p_side = r_side[k-1];
            assign p_v    = r_v[k-1];
        end

        assign n_stx = nnba_pkg::div_step(p_rx, p_nx[NW-1], i_den_x);
        assign n_sty = nnba_pkg::div_step(p_ry, p_ny[NW-1], i_den_y);

        // Advance stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        // Advance stage payload: shift in one quotient bit per lane
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rx[k]   <= n_stx[DW:1];
                r_ry[k]   <= n_sty[DW:1];
                r_qx[k]   <= {p_qx[NW-2:0], n_stx[0]};
                r_qy[k]   <= {p_qy[NW-2:0], n_sty[0]};
                r_nx[k]   <= {p_nx[NW-2:0], 1'b0};
                r_ny[k]   <= {p_ny[NW-2:0], 1'b0};
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quo_x = r_qx[NW-1];
    assign o_quo_y = r_qy[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

// ===== rtl/nnba_front.sv =====
// ----------------------------------------------------------------------------
// nnba_front
// Accepts pixel transactions, drops those that yield no result, and computes
// the source and canvas base addresses through a stallable pipeline.
// ----------------------------------------------------------------------------
module nnba_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  nnba_pkg::t_cfg        i_cfg,
    input  logic                  i_push,
    input  nnba_pkg::t_in         i_item,
    output logic                  o_full,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output nnba_pkg::t_entry      o_q_data
);

    localparam int NW = nnba_pkg::NUM_W;
    localparam int SW = nnba_pkg::SIZE_W;
    localparam int CW = nnba_pkg::CANW_W;
    localparam int AS = nnba_pkg::SRCA_W;
    localparam int AC = nnba_pkg::CANA_W;

    logic                 en;
    logic                 nonempty;
    logic [SW-1:0]        den_x, den_y;
    logic [SW-1:0]        sw_m1, sh_m1;

    logic                 r_a_v;
    nnba_pkg::t_in        r_a_item;
    logic                 r_b_v;
    logic [NW-1:0]        r_b_nx, r_b_ny;
    nnba_pkg::t_div_side  r_b_side;

    logic                 div_v;
    logic [NW-1:0]        div_qx, div_qy;
    nnba_pkg::t_div_side  div_side;

    logic                 r_e_v;
    logic [SW-1:0]        r_e_sx, r_e_sy;
    nnba_pkg::t_div_side  r_e_side;

    logic                 r_f_v;
    logic [AS-1:0]        r_f_py;
    logic [AC-1:0]        r_f_pc;
    logic [SW-1:0]        r_f_sx;
    logic [CW-1:0]        r_f_cx;

    logic                 r_g_v;
    nnba_pkg::t_entry     r_g_entry;

    logic [AS-1:0]        src_sum;
    logic [AC-1:0]        can_sum;

    // Whole pipeline moves together unless the finished entry cannot leave
    assign en       = !(r_g_v && i_q_full);
    assign o_full   = !en;
    assign o_q_push = r_g_v && !i_q_full;
    assign o_q_data = r_g_entry;

    // Classify: an empty source or no canvas channels gives no result
    assign nonempty = (i_cfg.src_width != '0) && (i_cfg.src_height != '0) &&
                      (i_cfg.src_channels != '0) && (i_cfg.canvas_channels != '0);

    assign den_x = (i_cfg.region_width  == '0) ? SW'(1) : i_cfg.region_width;
    assign den_y = (i_cfg.region_height == '0) ? SW'(1) : i_cfg.region_height;
    assign sw_m1 = i_cfg.src_width  - SW'(1);
    assign sh_m1 = i_cfg.src_height - SW'(1);

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_push && nonempty;
            r_b_v <= r_a_v;
            r_e_v <= div_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
        end
    end

    // Hold the accepted item, then scale positions and form canvas coordinates
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_item    <= i_item;
            r_b_nx      <= NW'(r_a_item.region_col) * NW'(i_cfg.src_width);
            r_b_ny      <= NW'(r_a_item.region_row) * NW'(i_cfg.src_height);
            r_b_side.cy <= CW'(r_a_item.origin_y) + CW'(r_a_item.region_row);
            r_b_side.cx <= CW'(r_a_item.origin_x) + CW'(r_a_item.region_col);
        end
    end

    nnba_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_v),
        .i_num_x (r_b_nx),
        .i_num_y (r_b_ny),
        .i_den_x (den_x),
        .i_den_y (den_y),
        .i_side  (r_b_side),
        .o_valid (div_v),
        .o_quo_x (div_qx),
        .o_quo_y (div_qy),
        .o_side  (div_side)
    );

    assign src_sum = r_f_py + AS'(r_f_sx);
    assign can_sum = r_f_pc + AC'(r_f_cx);

    // Clamp to the last source pixel, then build row offsets, then scale by channel counts
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_sx   <= (div_qx > NW'(sw_m1)) ? sw_m1 : div_qx[SW-1:0];
            r_e_sy   <= (div_qy > NW'(sh_m1)) ? sh_m1 : div_qy[SW-1:0];
            r_e_side <= div_side;

            r_f_py   <= AS'(r_e_sy) * AS'(i_cfg.src_width);
            r_f_pc   <= AC'(r_e_side.cy) * AC'(i_cfg.canvas_width);
            r_f_sx   <= r_e_sx;
            r_f_cx   <= r_e_side.cx;

            r_g_entry.src_base <= src_sum * AS'(i_cfg.src_channels);
            r_g_entry.can_base <= can_sum * AC'(i_cfg.canvas_channels);
        end
    end

endmodule

// ===== rtl/nnba_fifo.sv =====
// ----------------------------------------------------------------------------
// nnba_fifo
// Small show-ahead queue of per-pixel base addresses between front and back.
// ----------------------------------------------------------------------------
module nnba_fifo #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  nnba_pkg::t_entry   i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output nnba_pkg::t_entry   o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nnba_pkg::t_entry  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp, r_rp;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store incoming entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/nnba_back.sv =====
// ----------------------------------------------------------------------------
// nnba_back
// Expands each queued pixel into one address pair per canvas channel (at most
// MAX_CHANNELS) and holds the oldest result in an output register.
// ----------------------------------------------------------------------------
module nnba_back #(
    parameter int MAX_CHANNELS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nnba_pkg::t_cfg     i_cfg,
    input  logic               i_q_empty,
    input  nnba_pkg::t_entry   i_head,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output nnba_pkg::t_out     o_item
);

    localparam int CHW = nnba_pkg::CH_W;
    localparam int CIW = nnba_pkg::CIDX_W;

    logic [CIW-1:0]   r_ch;
    logic             r_ov;
    nnba_pkg::t_out   r_out;
    nnba_pkg::t_out   n_out;

    logic             load;
    logic             issue;
    logic             is_last;
    logic [CHW-1:0]   lim;
    logic [CHW-1:0]   last_ch;
    logic [CHW-1:0]   sc_m1;
    logic [CHW-1:0]   src_ch;

    // Output register frees when empty or when its result is taken
    assign load    = !r_ov || i_pop;
    assign issue   = load && !i_q_empty;

    assign lim     = (i_cfg.canvas_channels > CHW'(MAX_CHANNELS)) ?
                     CHW'(MAX_CHANNELS) : i_cfg.canvas_channels;
    assign last_ch = lim - CHW'(1);
    assign is_last = ({1'b0, r_ch} == last_ch);
    assign o_q_pop = issue && is_last;

    // Source channel saturates at the last source channel
    assign sc_m1   = i_cfg.src_channels - CHW'(1);
    assign src_ch  = ({1'b0, r_ch} < sc_m1) ? {1'b0, r_ch} : sc_m1;

    always_comb begin
        n_out.source_address = i_head.src_base + nnba_pkg::SRCA_W'(src_ch);
        n_out.canvas_address = i_head.can_base + nnba_pkg::CANA_W'(r_ch);
        n_out.channel_index  = r_ch;
        n_out.last           = is_last;
    end

    // Step through channels and load the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_ch <= '0;
        end else begin
            if (load) begin
                r_ov <= issue;
            end
            if (issue) begin
                r_ch <= is_last ? '0 : r_ch + CIW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_out <= n_out;
        end
    end

    assign o_empty = !r_ov;
    assign o_item  = r_out;

endmodule

// ===== rtl/nearest_neighbor_blit_addresser_top.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_blit_addresser_top
// Path: a pixel passes the front pipeline with its one-bit-per-stage pipelined
// divider, then the queue, the channel sequencer and the output register.
// Pixel rate is set by the back-end channel sequencer, which issues one result
// per cycle while the queue holds a pixel and the output register is free.
// Reset: synchronous, clears the pipeline, queue and output register, and
// loads the configuration defaults.
// ----------------------------------------------------------------------------
module nearest_neighbor_blit_addresser_top #(
    parameter int MAX_CHANNELS = 4,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [nnba_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [nnba_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic                                  push,
    input  nnba_pkg::t_in                         i_in_data,
    output logic                                  full,
    input  logic                                  pop,
    output logic                                  empty,
    output nnba_pkg::t_out                        o_out_data
);

    nnba_pkg::t_cfg    r_cfg;
    logic              q_full, q_empty, q_push, q_pop;
    nnba_pkg::t_entry  q_in, q_head;

    // Write configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width       <= '0;
            r_cfg.src_height      <= '0;
            r_cfg.src_channels    <= '0;
            r_cfg.region_width    <= nnba_pkg::SIZE_W'(1);
            r_cfg.region_height   <= nnba_pkg::SIZE_W'(1);
            r_cfg.canvas_width    <= nnba_pkg::CANW_W'(1);
            r_cfg.canvas_channels <= nnba_pkg::CH_W'(3);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nnba_pkg::REG_SRC_WIDTH: begin
                    r_cfg.src_width <= i_cfg_wdata[nnba_pkg::SIZE_W-1:0];
                end
                nnba_pkg::REG_SRC_HEIGHT: begin
                    r_cfg.src_height <= i_cfg_wdata[nnba_pkg::SIZE_W-1:0];
                end
                nnba_pkg::REG_SRC_CHANNELS: begin
                    r_cfg.src_channels <= i_cfg_wdata[nnba_pkg::CH_W-1:0];
                end
                nnba_pkg::REG_REGION_WIDTH: begin
                    r_cfg.region_width <= i_cfg_wdata[nnba_pkg::SIZE_W-1:0];
                end
                nnba_pkg::REG_REGION_HEIGHT: begin
                    r_cfg.region_height <= i_cfg_wdata[nnba_pkg::SIZE_W-1:0];
                end
                nnba_pkg::REG_CANVAS_WIDTH: begin
                    r_cfg.canvas_width <= i_cfg_wdata[nnba_pkg::CANW_W-1:0];
                end
                nnba_pkg::REG_CANVAS_CHANNELS: begin
                    r_cfg.canvas_channels <= i_cfg_wdata[nnba_pkg::CH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    nnba_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .i_item   (i_in_data),
        .o_full   (full),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_in)
    );

    nnba_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_head)
    );

    nnba_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_head    (q_head),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_out_data)
    );

endmodule
